>>> design/deq_pkg.sv
// Package for the double-ended queue: request codes and fixed port widths.
// No dependencies; imported by double_ended_queue and tb_top.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int FUNC_W  = 2;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_PUSH_BACK = 2'd0;
  localparam func_t FUNC_POP_FRONT = 2'd1;
  localparam func_t FUNC_POP_BACK  = 2'd2;
  localparam func_t FUNC_READ_AT   = 2'd3;

  // Status carried from the request cycle to the result cycle.
  typedef struct packed {
    logic               hit;
    logic               overflow;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } res_stat_t;

endpackage

>>> design/double_ended_queue.sv
// Double-ended queue top level: ring of DEPTH entries in one synchronous memory.
// Depends on deq_pkg for request codes, port widths and the result status struct.
// A result strobes on done in the cycle after its request is accepted.
// Throughput: one request per cycle; the ring pointers update in the accept cycle
//   and the memory serves at most one write (push) or one read (pop, read) per request.
// busy stays low; every start is taken.
// Reset (rst, synchronous): empties the queue and zeroes the head; memory contents
//   are left as they are and are only read once written.
`timescale 1ns / 1ps

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  func_t              func,
  input  logic [DATA_W-1:0]  value,
  input  logic [INDEX_W-1:0] index,
  output logic               done,
  output logic [DATA_W-1:0]  data,
  output logic               valid_res,
  output logic               overflow,
  output logic [COUNT_W-1:0] count,
  output logic               empty_res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Entry storage: one write port, one registered read port.
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data;

  // Ring state.
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] occ, occ_next;

  // Result stage.
  res_stat_t stat, stat_next;

  logic             accept;
  logic             wr_en, rd_en;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic [WIDTH-1:0] value_w;
  logic             full, idx_hit;
  logic [63:0]      rd_wide;

  // Map an offset from the front onto a ring slot; offsets stay at or below DEPTH,
  // so a single compare and subtract wraps the sum.
  function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign value_w = WIDTH'(64'(value));
  assign full    = (occ == CNT_W'(DEPTH));
  assign idx_hit = (CMP_W'(index) < CMP_W'(occ));

  // Decode the request: pick the memory access and the next ring state.
  always_comb begin
    head_next = head;
    occ_next  = occ;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = slot_at(head, occ);
    rd_addr   = head;
    stat_next = '0;
    unique case (func)
      FUNC_PUSH_BACK: begin
        if (full) begin
          stat_next.overflow = 1'b1;  // drop the value, keep the state
        end else begin
          wr_en    = accept;
          occ_next = occ + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (occ != '0) begin
          rd_en         = accept;
          rd_addr       = head;
          stat_next.hit = 1'b1;
          occ_next      = occ - 1'b1;
          head_next     = slot_at(head, CNT_W'(1));
        end
      end
      FUNC_POP_BACK: begin
        if (occ != '0) begin
          rd_en         = accept;
          rd_addr       = slot_at(head, occ - 1'b1);
          stat_next.hit = 1'b1;
          occ_next      = occ - 1'b1;
        end
      end
      FUNC_READ_AT: begin
        if (idx_hit) begin
          rd_en         = accept;
          rd_addr       = slot_at(head, CNT_W'(index));
          stat_next.hit = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // A drained queue restarts at slot zero.
    if (occ_next == '0) begin
      head_next = '0;
    end
    stat_next.count = COUNT_W'(occ_next);
    stat_next.empty = (occ_next == '0);
  end

  // Memory write and registered read; one request never does both.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Advance ring state and the result stage on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        head <= head_next;
        occ  <= occ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat <= stat_next;
    end
  end

  // Zero the data field when no entry came out of the ring.
  assign rd_wide   = 64'(rd_data);
  assign data      = stat.hit ? rd_wide[DATA_W-1:0] : '0;
  assign valid_res = stat.hit;
  assign overflow  = stat.overflow;
  assign count     = stat.count;
  assign empty_res = stat.empty;

  // Occupancy never runs past the ring size.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("occupancy exceeds DEPTH");

  // An empty ring always has its head at slot zero.
  a_head_home: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> (head == '0))
    else $error("empty queue with head away from slot zero");

  // A dropped push delivers no entry and leaves a non-empty queue.
  a_ovf_result: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (!valid_res && !empty_res))
    else $error("overflow result carries an entry or reports empty");

  // Each accepted request yields exactly one result on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted request produced no result");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for double_ended_queue: directed corner cases, then random traffic.
// Depends on deq_pkg for request codes and port widths; needs only the RTL to run.
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  localparam int RING_DEPTH   = 16;
  localparam int SETTLE_TICKS = 4;     // the block answers in the cycle after the transfer
  localparam int REPLY_WAIT   = 1000;  // bound on waiting for outstanding results
  localparam int SHOWN_FAULTS = 10;

  // One expected result, field for field as the block reports it.
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               valid;
    logic               ovf;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } deq_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  func_t              func = FUNC_PUSH_BACK;
  logic [DATA_W-1:0]  value = '0;
  logic [INDEX_W-1:0] index = '0;
  logic               done;
  logic [DATA_W-1:0]  data;
  logic               valid_res;
  logic               overflow;
  logic [COUNT_W-1:0] count;
  logic               empty_res;

  // Predicted queue contents, kept in a ring like the block's own.
  logic [DATA_W-1:0]  deq_ring [RING_DEPTH];
  logic [INDEX_W-1:0] ring_head = '0;
  int unsigned        ring_held = 0;

  deq_reply_t reply_q [$];   // results predicted but not yet seen on the ports
  deq_reply_t seen_reply;
  int         faults = 0;
  int         sender_idle_pct = 0;

  double_ended_queue #(
    .DEPTH (RING_DEPTH),
    .WIDTH (DATA_W)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .value     (value),
    .index     (index),
    .done      (done),
    .data      (data),
    .valid_res (valid_res),
    .overflow  (overflow),
    .count     (count),
    .empty_res (empty_res)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs or never answers.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Ring slot at a given distance from the front; the 4-bit sum wraps the ring.
  function automatic logic [INDEX_W-1:0] ring_slot(int unsigned offset);
    return ring_head + INDEX_W'(offset);
  endfunction

  // Apply one accepted request to the predicted queue and queue up its result.
  function automatic void model_request(func_t f, logic [DATA_W-1:0] v,
                                        logic [INDEX_W-1:0] idx);
    deq_reply_t r;
    r = '0;
    case (f)
      FUNC_PUSH_BACK: begin
        // Drop the value when the ring is full; only the flag changes.
        if (ring_held >= RING_DEPTH) begin
          r.ovf = 1'b1;
        end else begin
          deq_ring[ring_slot(ring_held)] = v;
          ring_held++;
        end
      end
      FUNC_POP_FRONT: begin
        if (ring_held > 0) begin
          r.data  = deq_ring[ring_slot(0)];
          r.valid = 1'b1;
          ring_head = ring_slot(1);
          ring_held--;
          if (ring_held == 0) ring_head = '0;  // drained: head returns home
        end
      end
      FUNC_POP_BACK: begin
        if (ring_held > 0) begin
          r.data  = deq_ring[ring_slot(ring_held - 1)];
          r.valid = 1'b1;
          ring_held--;
          if (ring_held == 0) ring_head = '0;
        end
      end
      FUNC_READ_AT: begin
        // Reads at or past the count deliver nothing.
        if (idx < ring_held) begin
          r.data  = deq_ring[ring_slot(idx)];
          r.valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(ring_held);
    r.empty = (ring_held == 0);
    reply_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Count every fault; show only the first few in detail.
  task automatic report_fault(string msg);
    faults++;
    if (faults <= SHOWN_FAULTS) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Each result is on the ports for one cycle only; take it at the edge closing it.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (reply_q.size() == 0) begin
        report_fault($sformatf("unexpected result data=%h valid=%0b ovf=%0b count=%0d",
                               data, valid_res, overflow, count));
      end else begin
        seen_reply = reply_q.pop_front();
        if (data !== seen_reply.data || valid_res !== seen_reply.valid ||
            overflow !== seen_reply.ovf || count !== seen_reply.count ||
            empty_res !== seen_reply.empty) begin
          report_fault({
            $sformatf("exp data=%h valid=%0b ovf=%0b count=%0d empty=%0b, ",
                      seen_reply.data, seen_reply.valid, seen_reply.ovf,
                      seen_reply.count, seen_reply.empty),
            $sformatf("got data=%h valid=%0b ovf=%0b count=%0d empty=%0b",
                      data, valid_res, overflow, count, empty_res)});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one request. Entered and left at a falling edge; idle gaps drop start,
  // otherwise start stays high straight into the next transfer.
  task automatic send_request(func_t f, logic [DATA_W-1:0] v, logic [INDEX_W-1:0] idx);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    func  = f;
    value = v;
    index = idx;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1'b1;
        model_request(f, v, idx);
      end
      @(negedge clk);
    end
  endtask

  // Hold off the sender until every predicted result has come, then let the
  // block settle. Whatever is still missing after the bound is a fault.
  task automatic wait_for_replies();
    start = 1'b0;
    for (int n = 0; n < REPLY_WAIT && reply_q.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
    while (reply_q.size() != 0) begin
      void'(reply_q.pop_front());
      report_fault("expected result never arrived");
    end
  endtask

  // Mostly random data, with the all-zero and all-one patterns now and then.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pops and reads on an empty queue deliver nothing and leave it empty.
  task automatic test_empty_requests();
    send_request(FUNC_POP_FRONT, '1, '0);
    send_request(FUNC_POP_BACK,  '1, '0);
    send_request(FUNC_READ_AT,   '0, '0);
    send_request(FUNC_READ_AT,   '1, '1);
  endtask

  // Extreme values, reads inside and past the count, fill to full, then overflow.
  task automatic test_fill_and_overflow();
    send_request(FUNC_PUSH_BACK, '0, '1);
    send_request(FUNC_PUSH_BACK, '1, '0);
    send_request(FUNC_READ_AT,   '0, 4'd0);
    send_request(FUNC_READ_AT,   '0, 4'd1);
    send_request(FUNC_READ_AT,   '0, 4'd2);   // at the count: past the end
    repeat (RING_DEPTH - 2)
      send_request(FUNC_PUSH_BACK, pick_value(), INDEX_W'($urandom_range(15)));
    send_request(FUNC_PUSH_BACK, 32'hDEAD_BEEF, '0);  // full: dropped, flagged
    send_request(FUNC_READ_AT,   '0, 4'd15);  // last slot of a full ring
  endtask

  // Move the head off slot zero, wrap a push around the ring, pop from the back.
  task automatic test_wrap_and_pops();
    send_request(FUNC_POP_FRONT, '0, '0);
    send_request(FUNC_PUSH_BACK, 32'hA5A5_5A5A, '0);
    send_request(FUNC_POP_BACK,  '0, '0);
    send_request(FUNC_READ_AT,   '0, 4'd15);  // count is 15 now: past the end
  endtask

  // Random traffic in bursts that lean toward filling, draining or neither, so
  // the occupancy sweeps from empty to full and back, crossing the drain point.
  task automatic test_random_traffic(int items, int idle_pct);
    int push_pct;
    int pick;
    logic [INDEX_W-1:0] idx;
    sender_idle_pct = idle_pct;
    push_pct = 50;
    for (int i = 0; i < items; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      // Reads mostly land on live entries, sometimes anywhere in the index range.
      if (ring_held > 0 && $urandom_range(3) != 0)
        idx = INDEX_W'($urandom_range(ring_held - 1));
      else idx = INDEX_W'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < push_pct)
        send_request(FUNC_PUSH_BACK, pick_value(), INDEX_W'($urandom_range(15)));
      else begin
        case ($urandom_range(2))
          0:       send_request(FUNC_POP_FRONT, pick_value(), idx);
          1:       send_request(FUNC_POP_BACK,  pick_value(), idx);
          default: send_request(FUNC_READ_AT,   pick_value(), idx);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Hold reset, then release it away from the sampling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    sender_idle_pct = 29;
    test_empty_requests();
    test_fill_and_overflow();
    test_wrap_and_pops();
    wait_for_replies();

    // Sender idles at 29 percent, then 54 percent, then never; pause fully
    // between phases.
    test_random_traffic(170, 29);
    wait_for_replies();
    test_random_traffic(170, 54);
    wait_for_replies();
    test_random_traffic(170, 0);
    wait_for_replies();

    if (faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/deq_pkg.sv
design/double_ended_queue.sv
test/tb_top.sv
